// ===== sv/u2u8_pkg.sv =====
// shared types and constants for the utf-16le to utf-8 stream unit
// no dependencies
`timescale 1ns / 1ps

package u2u8_pkg;

  // most output bytes that one input byte can cause
  localparam int MaxBytes = 4;
  localparam int IdxW     = $clog2(MaxBytes);

  // default depth of the queue between front and back
  localparam int QueueDepth = 2;

  localparam logic [15:0] Lim1Byte   = 16'h0080;
  localparam logic [15:0] Lim2Byte   = 16'h0800;
  localparam logic [15:0] SurrBase   = 16'hD800;
  localparam logic [15:0] SurrEnd    = 16'hE000;
  localparam logic [5:0]  HighTag    = 6'b110110;
  localparam logic [5:0]  LowTag     = 6'b110111;
  localparam logic [20:0] PlaneBase  = 21'h10000;

  localparam logic [7:0] Qmark    = 8'h3F;
  localparam logic [7:0] LeadTwo  = 8'hC0;
  localparam logic [7:0] LeadThr  = 8'hE0;
  localparam logic [7:0] LeadFour = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;

  // one batch of output bytes caused by one input byte
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
  } job_t;

endpackage

// ===== sv/utf16le_to_utf8_stream_unit.sv =====
// top level of the utf-16le to utf-8 stream unit
// depends on u2u8_pkg, u2u8_front, u2u8_queue, u2u8_back
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// in      | in        | in_valid_i / in_stall_o   | in_byte_i, end_of_text_i
// out     | out       | out_valid_o / out_stall_i | utf8_byte_o, last_of_run_o
//
// the front takes one byte a cycle while the queue has room; a batch of 1 to 4
// bytes is made only when a code unit completes or text ends, none while a high
// surrogate waits for its pair; the back sends one byte a cycle unless out_stall_i
// is high, and a code unit's bytes go out once its batch reaches the queue head
// reset clears the byte pairing, surrogate state, queue and byte index
// out_stall_i only holds the back; the front runs on until the queue fills

module utf16le_to_utf8_stream_unit #(
  parameter int QueueDepth = u2u8_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] utf8_byte_o,
  output logic       last_of_run_o
);

  // batch hand-off from front to queue
  logic           push;
  logic           full;
  u2u8_pkg::job_t push_job;

  // head of queue into the back
  logic           pop;
  logic           empty;
  u2u8_pkg::job_t head_job;

  // classify each byte and build the output batch of a code unit
  u2u8_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (full),
    .push_o        (push),
    .push_job_o    (push_job)
  );

  // decouples the two sides so either can stall alone
  u2u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_job_o (head_job)
  );

  // serialize the head batch, flag its last byte
  u2u8_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_job_i    (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .utf8_byte_o   (utf8_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== sv/u2u8_front.sv =====
// front part: pairs bytes into code units, tracks surrogates, builds byte batches
// depends on u2u8_pkg
`timescale 1ns / 1ps

module u2u8_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_text_i,
  input  logic             q_full_i,
  output logic             push_o,
  output u2u8_pkg::job_t   push_job_o
);

  logic       phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [9:0] hbits_q, hbits_d;
  logic       pend_q, pend_d;

  logic        accept;
  logic [15:0] unit;
  logic [20:0] cp;
  logic [2:0]  n;
  logic [1:0]  off;
  logic [u2u8_pkg::MaxBytes-1:0][7:0] b;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign unit       = {in_byte_i, held_q};
  assign cp         = u2u8_pkg::PlaneBase + {1'b0, hbits_q, unit[9:0]};

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    hbits_d = hbits_q;
    pend_d  = pend_q;
    b       = '0;
    n       = 3'd0;
    off     = 2'd0;
    if (!phase_q) begin
      held_d  = in_byte_i;
      phase_d = 1'b1;
    end else begin
      phase_d = 1'b0;
      held_d  = 8'h00;
      if (pend_q && unit[15:10] == u2u8_pkg::LowTag) begin
        b[0]    = u2u8_pkg::LeadFour | {5'b0, cp[20:18]};
        b[1]    = u2u8_pkg::ContMark | {2'b0, cp[17:12]};
        b[2]    = u2u8_pkg::ContMark | {2'b0, cp[11:6]};
        b[3]    = u2u8_pkg::ContMark | {2'b0, cp[5:0]};
        n       = 3'd4;
        pend_d  = 1'b0;
        hbits_d = 10'h000;
      end else begin
        // unpaired high surrogate goes out as a question mark first
        if (pend_q) begin
          b[0]    = u2u8_pkg::Qmark;
          off     = 2'd1;
          pend_d  = 1'b0;
          hbits_d = 10'h000;
        end
        n = {1'b0, off};
        if (unit < u2u8_pkg::Lim1Byte) begin
          b[off] = unit[7:0];
          n      = n + 3'd1;
        end else if (unit < u2u8_pkg::Lim2Byte) begin
          b[off]        = u2u8_pkg::LeadTwo | {3'b0, unit[10:6]};
          b[off + 2'd1] = u2u8_pkg::ContMark | {2'b0, unit[5:0]};
          n             = n + 3'd2;
        end else if (unit < u2u8_pkg::SurrBase || unit >= u2u8_pkg::SurrEnd) begin
          b[off]        = u2u8_pkg::LeadThr | {4'b0, unit[15:12]};
          b[off + 2'd1] = u2u8_pkg::ContMark | {2'b0, unit[11:6]};
          b[off + 2'd2] = u2u8_pkg::ContMark | {2'b0, unit[5:0]};
          n             = n + 3'd3;
        end else if (unit[15:10] == u2u8_pkg::HighTag) begin
          hbits_d = unit[9:0];
          pend_d  = 1'b1;
        end else begin
          // lone low surrogate
          b[off] = u2u8_pkg::Qmark;
          n      = n + 3'd1;
        end
      end
    end
    if (end_of_text_i) begin
      // a high surrogate still waiting at the end of text
      if (pend_d) begin
        b[n[1:0]] = u2u8_pkg::Qmark;
        n         = n + 3'd1;
      end
      phase_d = 1'b0;
      held_d  = 8'h00;
      hbits_d = 10'h000;
      pend_d  = 1'b0;
    end
  end

  assign push_o              = accept && (n != 3'd0);
  assign push_job_o.bytes    = b;
  assign push_job_o.last_idx = u2u8_pkg::IdxW'(n - 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      held_q  <= 8'h00;
      hbits_q <= 10'h000;
      pend_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      hbits_q <= hbits_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ===== sv/u2u8_queue.sv =====
// short queue of byte batches between front and back
// depends on u2u8_pkg
`timescale 1ns / 1ps

module u2u8_queue #(
  parameter int Depth = u2u8_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u2u8_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output u2u8_pkg::job_t head_job_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);

  u2u8_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign head_job_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
    end
  end

endmodule

// ===== sv/u2u8_back.sv =====
// back part: sends the bytes of the head batch one per cycle while out_stall_i is low
// depends on u2u8_pkg
`timescale 1ns / 1ps

module u2u8_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  u2u8_pkg::job_t head_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     utf8_byte_o,
  output logic           last_of_run_o
);

  logic [u2u8_pkg::IdxW-1:0] idx_q;
  logic                      take;

  assign out_valid_o   = !empty_i;
  assign utf8_byte_o   = head_job_i.bytes[idx_q];
  assign last_of_run_o = (idx_q == head_job_i.last_idx);
  assign take          = out_valid_o && !out_stall_i;
  assign pop_o         = take && last_of_run_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= last_of_run_o ? '0 : idx_q + u2u8_pkg::IdxW'(1);
    end
  end

endmodule
